// ===== sv/word_substring_matcher_defines.svh =====
// Assertion macros shared by the word substring matcher RTL.
`ifndef WORD_SUBSTRING_MATCHER_DEFINES_SVH
`define WORD_SUBSTRING_MATCHER_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define WSM_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define WSM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WSM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/wsm_pkg.sv =====
// Shared types, constants and character helpers of the word substring matcher.
`default_nettype none

package wsm_pkg;

   // Sizing of the pattern and the counters.
   localparam int PAT_MAX        = 32;
   localparam int COUNT_BITS     = 16;
   localparam int CHAR_BITS      = 8;
   localparam int NUM_PAT_WORDS  = 4;
   localparam int PAT_WORD_BITS  = 64;
   localparam int LEN_REG_BITS   = 6;
   localparam int LEN_EFF_BITS   = $clog2(PAT_MAX + 1);
   localparam int WIN_BITS       = PAT_MAX * CHAR_BITS;

   // Widths of the result fields.
   localparam int FIELD_BITS     = 16;
   localparam int CSR_INDEX_BITS = 3;

   // Output queue sizing; two entries stay free for an end-of-text request.
   localparam int FIFO_DEPTH       = 4;
   localparam int FIFO_PTR_BITS    = $clog2(FIFO_DEPTH);
   localparam int FIFO_LEVEL_BITS  = $clog2(FIFO_DEPTH + 1);

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PATTERN_LENGTH = 3'd0,
      REG_PATTERN_WORD_0 = 3'd1,
      REG_PATTERN_WORD_1 = 3'd2,
      REG_PATTERN_WORD_2 = 3'd3,
      REG_PATTERN_WORD_3 = 3'd4
   } csr_index_type;

   // Request kinds.
   typedef enum logic {
      KIND_CHAR = 1'b0,
      KIND_END  = 1'b1
   } kind_type;

   // One result item.
   typedef struct packed {
      logic [FIELD_BITS-1:0] word_index;
      logic [FIELD_BITS-1:0] match_count;
      logic                  is_summary;
      logic                  last;
   } rsp_item_type;

   // Results produced by one request, first to second.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } push_type;

   // Output queue status seen by the top level.
   typedef struct packed {
      logic [FIFO_LEVEL_BITS-1:0] level;
      logic                       ready;
   } fifo_status_type;

   // Only A to Z fold to lower case.
   function automatic logic [CHAR_BITS-1:0] fold(input logic [CHAR_BITS-1:0] c);
      logic [CHAR_BITS-1:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

   // ASCII letters and digits make up words.
   function automatic logic is_word_char(input logic [CHAR_BITS-1:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

endpackage

`default_nettype wire

// ===== sv/word_substring_matcher.sv =====
// Top level of the case-insensitive word substring matcher.
// Usage:
//   The req channel carries one text byte per request in req_tdata, with
//   req_tuser low; req_tuser high marks end of text. Words are runs of ASCII
//   letters and digits. Each word that contains the configured pattern,
//   ignoring case, yields one result on the rsp channel when the word ends:
//   word number in rsp_tdata[15:0], running match count in rsp_tdata[31:16].
//   End of text yields a summary (rsp_tuser high, rsp_tlast high) after the
//   result of a matching open word, then clears the word and match counts.
//   The csr port writes the pattern length and four pattern words.
//   One request is taken every cycle while req_tready is high; the
//   comparison of the whole window against the pattern is combinational.
//   A four-entry result queue separates the two channels, so requests keep
//   flowing while a result waits. When rsp_tready stays low, req_tready
//   drops once fewer than two queue entries are free. Synchronous reset
//   clears the counters, the word state, the queue and the configuration
//   registers.
`default_nettype none
`include "word_substring_matcher_defines.svh"

module word_substring_matcher (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Request channel.
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [7:0]                            req_tdata,  // char_code[7:0]
   input  wire logic                                  req_tuser,  // kind[0]
   // Result channel.
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [31:0]                                rsp_tdata,  // word_index, match_count
   output logic                                       rsp_tuser,  // is_summary[0]
   output logic                                       rsp_tlast,
   // Configuration port.
   input  wire logic                                  csr_wr_en,
   input  wire logic [wsm_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [wsm_pkg::PAT_WORD_BITS-1:0]     csr_data
);

   logic [wsm_pkg::LEN_EFF_BITS-1:0]  pat_len_eff;
   logic [wsm_pkg::WIN_BITS-1:0]      pat_fold;
   logic                              req_accept;
   wsm_pkg::push_type                 push;
   wsm_pkg::rsp_item_type             head;
   wsm_pkg::fifo_status_type          status;

   wsm_cfg_regs u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .pat_len_eff (pat_len_eff),
      .pat_fold    (pat_fold)
   );

   assign req_tready = status.ready;
   assign req_accept = req_tvalid & req_tready;

   wsm_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .kind        (req_tuser),
      .char_code   (req_tdata),
      .pat_len_eff (pat_len_eff),
      .pat_fold    (pat_fold),
      .push        (push)
   );

   wsm_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop_ready (rsp_tready),
      .pop_valid (rsp_tvalid),
      .pop_item  (head),
      .status    (status)
   );

   // Result payload packing.
   assign rsp_tdata = {head.match_count, head.word_index};
   assign rsp_tuser = head.is_summary;
   assign rsp_tlast = head.last;

   // The queue never holds more entries than it has.
   `WSM_ASSERT_ALWAYS(a_fifo_bound, clock, reset,
      status.level <= wsm_pkg::FIFO_LEVEL_BITS'(wsm_pkg::FIFO_DEPTH),
      "result queue overflow")
   // A summary ends its request and carries no word number.
   `WSM_ASSERT_SAME(a_summary_form, clock, reset, rsp_tvalid && rsp_tuser,
      rsp_tlast && rsp_tdata[15:0] == 16'd0, "malformed summary result")
   // A result without last is always followed by the summary already queued.
   `WSM_ASSERT_NEXT(a_summary_follows, clock, reset,
      rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && rsp_tuser,
      "summary missing after word result")

endmodule

`default_nettype wire

// ===== sv/wsm_cfg_regs.sv =====
// Pattern configuration registers with the folded, length-limited pattern view.
`default_nettype none

module wsm_cfg_regs (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        csr_wr_en,
   input  wire logic [wsm_pkg::CSR_INDEX_BITS-1:0]          csr_index,
   input  wire logic [wsm_pkg::PAT_WORD_BITS-1:0]           csr_data,
   output logic      [wsm_pkg::LEN_EFF_BITS-1:0]            pat_len_eff,
   output logic      [wsm_pkg::WIN_BITS-1:0]                pat_fold
);

   logic [wsm_pkg::LEN_REG_BITS-1:0]  len_ff;
   logic [wsm_pkg::PAT_WORD_BITS-1:0] word_ff [wsm_pkg::NUM_PAT_WORDS];

   // Register writes, decoded by index; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         for (int i = 0; i < wsm_pkg::NUM_PAT_WORDS; i++) begin
            word_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         unique case (wsm_pkg::csr_index_type'(csr_index))
            wsm_pkg::REG_PATTERN_LENGTH: len_ff <= csr_data[wsm_pkg::LEN_REG_BITS-1:0];
            wsm_pkg::REG_PATTERN_WORD_0: word_ff[0] <= csr_data;
            wsm_pkg::REG_PATTERN_WORD_1: word_ff[1] <= csr_data;
            wsm_pkg::REG_PATTERN_WORD_2: word_ff[2] <= csr_data;
            wsm_pkg::REG_PATTERN_WORD_3: word_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // A length above the window size is limited to the window size.
   always_comb begin
      if (32'(len_ff) > 32'(wsm_pkg::PAT_MAX)) begin
         pat_len_eff = wsm_pkg::LEN_EFF_BITS'(wsm_pkg::PAT_MAX);
      end else begin
         pat_len_eff = wsm_pkg::LEN_EFF_BITS'(len_ff);
      end
   end

   // Folded pattern bytes; positions beyond the stored words read as zero.
   for (genvar j = 0; j < wsm_pkg::PAT_MAX; j++) begin : g_pat
      if (j < wsm_pkg::NUM_PAT_WORDS * 8) begin : g_stored
         assign pat_fold[8*j +: 8] = wsm_pkg::fold(word_ff[j / 8][8*(j % 8) +: 8]);
      end else begin : g_empty
         assign pat_fold[8*j +: 8] = '0;
      end
   end

endmodule

`default_nettype wire

// ===== sv/wsm_scan.sv =====
// Word tracking, window compare and counters; one accepted request per cycle.
`default_nettype none

module wsm_scan (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 accept,
   input  wire logic                                 kind,
   input  wire logic [wsm_pkg::CHAR_BITS-1:0]        char_code,
   input  wire logic [wsm_pkg::LEN_EFF_BITS-1:0]     pat_len_eff,
   input  wire logic [wsm_pkg::WIN_BITS-1:0]         pat_fold,
   output wsm_pkg::push_type                         push
);

   // Newest character sits in the top byte of the window.
   logic [wsm_pkg::WIN_BITS-1:0]      window_ff, window_in;
   logic [wsm_pkg::LEN_EFF_BITS-1:0]  chars_ff, chars_in;
   logic                              inside_ff, inside_in;
   logic                              matched_ff, matched_in;
   logic [wsm_pkg::COUNT_BITS-1:0]    word_cnt_ff, word_cnt_in;
   logic [wsm_pkg::COUNT_BITS-1:0]    hit_cnt_ff, hit_cnt_in;

   logic [wsm_pkg::CHAR_BITS-1:0]     folded;
   logic                              word_char;
   logic                              hit;
   logic [wsm_pkg::COUNT_BITS-1:0]    hit_cnt_next;
   logic [wsm_pkg::COUNT_BITS-1:0]    word_cnt_next;
   logic [wsm_pkg::WIN_BITS-1:0]      win_shift;
   logic [wsm_pkg::WIN_BITS-1:0]      aligned;
   logic [wsm_pkg::LEN_EFF_BITS-1:0]  shift_bytes;
   logic [wsm_pkg::LEN_EFF_BITS-1:0]  chars_base;
   logic [wsm_pkg::LEN_EFF_BITS-1:0]  chars_next;
   logic                              tail_eq;
   logic                              tail_hit;

   // Window shift and tail compare against the pattern.
   always_comb begin
      folded     = wsm_pkg::fold(char_code);
      word_char  = wsm_pkg::is_word_char(char_code);
      win_shift  = {folded, window_ff[wsm_pkg::WIN_BITS-1:wsm_pkg::CHAR_BITS]};
      chars_base = inside_ff ? chars_ff : '0;
      if (chars_base == wsm_pkg::LEN_EFF_BITS'(wsm_pkg::PAT_MAX)) begin
         chars_next = chars_base;
      end else begin
         chars_next = chars_base + 1'b1;
      end
      // Bring the last pattern-length characters down so byte j lines up
      // with pattern character j.
      shift_bytes = wsm_pkg::LEN_EFF_BITS'(wsm_pkg::PAT_MAX) - pat_len_eff;
      aligned     = win_shift >> {shift_bytes, 3'b000};
      tail_eq     = 1'b1;
      for (int j = 0; j < wsm_pkg::PAT_MAX; j++) begin
         if (wsm_pkg::LEN_EFF_BITS'(j) < pat_len_eff &&
             aligned[8*j +: 8] != pat_fold[8*j +: 8]) begin
            tail_eq = 1'b0;
         end
      end
      tail_hit = (pat_len_eff != '0) && (chars_next >= pat_len_eff) && tail_eq;
   end

   // Counter increments, saturating at all ones.
   always_comb begin
      hit = inside_ff & matched_ff;
      if (hit && hit_cnt_ff != '1) begin
         hit_cnt_next = hit_cnt_ff + 1'b1;
      end else begin
         hit_cnt_next = hit_cnt_ff;
      end
      if (word_cnt_ff != '1) begin
         word_cnt_next = word_cnt_ff + 1'b1;
      end else begin
         word_cnt_next = word_cnt_ff;
      end
   end

   // Next state and results of the accepted request.
   always_comb begin
      window_in   = window_ff;
      chars_in    = chars_ff;
      inside_in   = inside_ff;
      matched_in  = matched_ff;
      word_cnt_in = word_cnt_ff;
      hit_cnt_in  = hit_cnt_ff;
      push        = '0;
      if (accept) begin
         if (wsm_pkg::kind_type'(kind) == wsm_pkg::KIND_END) begin
            // Close any open word, then report the total and start over.
            if (hit) begin
               push.count              = 2'd2;
               push.first.word_index   = wsm_pkg::FIELD_BITS'(word_cnt_ff);
               push.first.match_count  = wsm_pkg::FIELD_BITS'(hit_cnt_next);
               push.second.match_count = wsm_pkg::FIELD_BITS'(hit_cnt_next);
               push.second.is_summary  = 1'b1;
               push.second.last        = 1'b1;
            end else begin
               push.count             = 2'd1;
               push.first.match_count = wsm_pkg::FIELD_BITS'(hit_cnt_next);
               push.first.is_summary  = 1'b1;
               push.first.last        = 1'b1;
            end
            chars_in    = '0;
            inside_in   = 1'b0;
            matched_in  = 1'b0;
            word_cnt_in = '0;
            hit_cnt_in  = '0;
         end else if (!word_char) begin
            // A separator closes the open word.
            if (hit) begin
               push.count             = 2'd1;
               push.first.word_index  = wsm_pkg::FIELD_BITS'(word_cnt_ff);
               push.first.match_count = wsm_pkg::FIELD_BITS'(hit_cnt_next);
               push.first.last        = 1'b1;
            end
            hit_cnt_in = hit_cnt_next;
            chars_in   = '0;
            inside_in  = 1'b0;
            matched_in = 1'b0;
         end else begin
            // A word character opens or extends a word.
            if (!inside_ff) begin
               word_cnt_in = word_cnt_next;
               matched_in  = (pat_len_eff == '0) | tail_hit;
            end else begin
               matched_in  = matched_ff | tail_hit;
            end
            inside_in = 1'b1;
            chars_in  = chars_next;
            window_in = win_shift;
         end
      end
   end

   // Word state and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         chars_ff    <= '0;
         inside_ff   <= 1'b0;
         matched_ff  <= 1'b0;
         word_cnt_ff <= '0;
         hit_cnt_ff  <= '0;
      end else begin
         chars_ff    <= chars_in;
         inside_ff   <= inside_in;
         matched_ff  <= matched_in;
         word_cnt_ff <= word_cnt_in;
         hit_cnt_ff  <= hit_cnt_in;
      end
   end

   // Character window; its contents only count once enough characters arrived.
   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

endmodule

`default_nettype wire

// ===== sv/wsm_out_fifo.sv =====
// Small result queue: up to two results in a cycle, one out while pop_ready.
`default_nettype none

module wsm_out_fifo (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire wsm_pkg::push_type         push,
   input  wire logic                      pop_ready,
   output logic                           pop_valid,
   output wsm_pkg::rsp_item_type          pop_item,
   output wsm_pkg::fifo_status_type       status
);

   wsm_pkg::rsp_item_type                 entry_ff [wsm_pkg::FIFO_DEPTH];
   logic [wsm_pkg::FIFO_PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [wsm_pkg::FIFO_PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [wsm_pkg::FIFO_LEVEL_BITS-1:0]   level_ff, level_in;
   logic [wsm_pkg::FIFO_PTR_BITS-1:0]     wr_ptr_second;
   logic                                  pop;

   // Pointer and level bookkeeping.
   always_comb begin
      pop           = pop_valid & pop_ready;
      wr_ptr_second = wr_ptr_ff + 1'b1;
      wr_ptr_in     = wr_ptr_ff + wsm_pkg::FIFO_PTR_BITS'(push.count);
      rd_ptr_in     = rd_ptr_ff + wsm_pkg::FIFO_PTR_BITS'(pop);
      level_in      = level_ff + wsm_pkg::FIFO_LEVEL_BITS'(push.count)
                      - wsm_pkg::FIFO_LEVEL_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Entry writes at the write pointer and the one after it.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_second] <= push.second;
      end
   end

   // Head of the queue and room for a worst-case request.
   always_comb begin
      pop_valid    = (level_ff != '0);
      pop_item     = entry_ff[rd_ptr_ff];
      status.level = level_ff;
      status.ready = (level_ff <= wsm_pkg::FIFO_LEVEL_BITS'(wsm_pkg::FIFO_DEPTH - 2));
   end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the case-insensitive word substring matcher.
`timescale 1ns / 1ps

module tb;
   import wsm_pkg::*;

   localparam int SLACK_CYCLES = 8;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 210;
   localparam int SHORT_WORDS  = 40;
   localparam int DIR_ROWS     = 28;

   typedef enum logic {
      ROW_REQ,
      ROW_PATTERN
   } row_op_type;

   // One row of the directed table; a pattern row carries the length in ch.
   typedef struct packed {
      row_op_type   op;
      kind_type     kind;
      logic [7:0]   ch;
      logic         typed;
      logic [1:0]   n;
      rsp_item_type e0;
      rsp_item_type e1;
      logic [63:0]  w0;
   } dir_row_type;

   localparam rsp_item_type NO_RSP = '0;

   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      // Reset configuration: every word matches.
      '{ROW_REQ, KIND_CHAR, 8'h41, 1'b1, 2'd0, NO_RSP, NO_RSP, 64'h0},
      '{ROW_REQ, KIND_CHAR, 8'h20, 1'b1, 2'd1, '{16'd1, 16'd1, 1'b0, 1'b1}, NO_RSP, 64'h0},
      '{ROW_REQ, KIND_CHAR, 8'h00, 1'b1, 2'd0, NO_RSP, NO_RSP, 64'h0},
      '{ROW_REQ, KIND_CHAR, 8'h7A, 1'b1, 2'd0, NO_RSP, NO_RSP, 64'h0},
      '{ROW_REQ, KIND_CHAR, 8'hFF, 1'b1, 2'd1, '{16'd2, 16'd2, 1'b0, 1'b1}, NO_RSP, 64'h0},
      '{ROW_REQ, KIND_CHAR, 8'h39, 1'b1, 2'd0, NO_RSP, NO_RSP, 64'h0},
      '{ROW_REQ, KIND_END, 8'h00, 1'b1, 2'd2, '{16'd3, 16'd3, 1'b0, 1'b0},
        '{16'd0, 16'd3, 1'b1, 1'b1}, 64'h0},
      '{ROW_REQ, KIND_END, 8'hFF, 1'b1, 2'd1, '{16'd0, 16'd0, 1'b1, 1'b1}, NO_RSP, 64'h0},
      // Mixed-case pattern "aB1" against upper and lower case text.
      '{ROW_PATTERN, KIND_CHAR, 8'd3, 1'b0, 2'd0, NO_RSP, NO_RSP, 64'h0000_0000_0031_4261},
      '{ROW_REQ, KIND_CHAR, 8'h58, 1'b0, 2'd0, NO_RSP, NO_RSP, 64'h0},
      '{ROW_REQ, KIND_CHAR, 8'h41, 1'b0, 2'd0, NO_RSP, NO_RSP, 64'h0},
      '{ROW_REQ, KIND_CHAR, 8'h62, 1'b0, 2'd0, NO_RSP, NO_RSP, 64'h0},
      '{ROW_REQ, KIND_CHAR, 8'h31, 1'b0, 2'd0, NO_RSP, NO_RSP, 64'h0},
      '{ROW_REQ, KIND_CHAR, 8'h40, 1'b0, 2'd0, NO_RSP, NO_RSP, 64'h0},
      '{ROW_REQ, KIND_CHAR, 8'h5B, 1'b0, 2'd0, NO_RSP, NO_RSP, 64'h0},
      '{ROW_REQ, KIND_CHAR, 8'h61, 1'b0, 2'd0, NO_RSP, NO_RSP, 64'h0},
      '{ROW_REQ, KIND_CHAR, 8'h62, 1'b0, 2'd0, NO_RSP, NO_RSP, 64'h0},
      '{ROW_REQ, KIND_CHAR, 8'h60, 1'b0, 2'd0, NO_RSP, NO_RSP, 64'h0},
      '{ROW_REQ, KIND_END, 8'h00, 1'b0, 2'd0, NO_RSP, NO_RSP, 64'h0},
      // Length above the maximum is clamped to a full-width pattern.
      '{ROW_PATTERN, KIND_CHAR, 8'd63, 1'b0, 2'd0, NO_RSP, NO_RSP, 64'h6161_6161_6161_6161},
      '{ROW_REQ, KIND_CHAR, 8'h61, 1'b0, 2'd0, NO_RSP, NO_RSP, 64'h0},
      '{ROW_REQ, KIND_CHAR, 8'h41, 1'b0, 2'd0, NO_RSP, NO_RSP, 64'h0},
      '{ROW_REQ, KIND_END, 8'h00, 1'b0, 2'd0, NO_RSP, NO_RSP, 64'h0},
      // A punctuation byte in the pattern can never match a word.
      '{ROW_PATTERN, KIND_CHAR, 8'd2, 1'b0, 2'd0, NO_RSP, NO_RSP, 64'h0000_0000_0000_612D},
      '{ROW_REQ, KIND_CHAR, 8'h61, 1'b0, 2'd0, NO_RSP, NO_RSP, 64'h0},
      '{ROW_REQ, KIND_CHAR, 8'h2D, 1'b0, 2'd0, NO_RSP, NO_RSP, 64'h0},
      '{ROW_REQ, KIND_CHAR, 8'h61, 1'b0, 2'd0, NO_RSP, NO_RSP, 64'h0},
      '{ROW_REQ, KIND_END, 8'h00, 1'b0, 2'd0, NO_RSP, NO_RSP, 64'h0}
   };

   localparam int PHASE_LEN [PHASES] = '{1, 3, 5, 32, 63, 0, 2, 8};
   localparam logic [7:0] ALPHABET [4] = '{8'h61, 8'h62, 8'h63, 8'h31};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata = 8'h00;
   logic                      req_tuser = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [31:0]               rsp_tdata;
   logic                      rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_wr_en = 1'b0;
   csr_index_type             csr_index = REG_PATTERN_LENGTH;
   logic [PAT_WORD_BITS-1:0]  csr_data = '0;

   // Idle percentages of both sides.
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;

   // Predictor copy of the configuration and the word state.
   logic [LEN_REG_BITS-1:0]   cfg_len = '0;
   logic [PAT_WORD_BITS-1:0]  cfg_words [NUM_PAT_WORDS];
   logic [7:0]                win [PAT_MAX];
   int                        word_chars = 0;
   logic                      in_word = 1'b0;
   logic                      word_hit = 1'b0;
   logic [COUNT_BITS-1:0]     word_cnt = '0;
   logic [COUNT_BITS-1:0]     hit_cnt = '0;

   // Pattern in use by the random text generator.
   logic [7:0]                cur_pat [PAT_MAX];
   int                        cur_eff = 0;

   rsp_item_type              pending_matches [$];
   int                        mismatch_count = 0;
   int                        sent_items = 0;

   word_substring_matcher u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   function automatic logic is_text_char(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic [7:0] pat_byte(input int k);
      return cfg_words[k / 8][8 * (k % 8) +: 8];
   endfunction

   // A random word character with random case.
   function automatic logic [7:0] pick_letter();
      logic [7:0] c;
      c = ALPHABET[$urandom_range(3)];
      if (c >= 8'h61 && $urandom_range(1) == 1) begin
         c = c ^ 8'h20;
      end
      return c;
   endfunction

   function automatic logic [7:0] pick_separator();
      logic [7:0] c;
      c = 8'h20;
      if ($urandom_range(1) == 1) begin
         c = 8'($urandom_range(255));
         while (is_text_char(c)) begin
            c = 8'($urandom_range(255));
         end
      end
      return c;
   endfunction

   // Closes the open word and counts it when it matched.
   function automatic logic close_word_hit();
      logic hit;
      hit = in_word && word_hit;
      if (hit && hit_cnt != '1) begin
         hit_cnt = hit_cnt + 1'b1;
      end
      for (int i = 0; i < PAT_MAX; i++) begin
         win[i] = 8'h00;
      end
      word_chars = 0;
      in_word = 1'b0;
      word_hit = 1'b0;
      return hit;
   endfunction

   // Works out the results that one text request causes.
   task automatic scan_text(input kind_type k, input logic [7:0] c, output int n,
                            output rsp_item_type res [2]);
      int  plen;
      logic eq;
      n = 0;
      res[0] = '0;
      res[1] = '0;
      if (k == KIND_END) begin
         if (close_word_hit()) begin
            res[n] = '{word_cnt, hit_cnt, 1'b0, 1'b0};
            n++;
         end
         res[n] = '{'0, hit_cnt, 1'b1, 1'b1};
         n++;
         word_cnt = '0;
         hit_cnt = '0;
      end else if (!is_text_char(c)) begin
         if (close_word_hit()) begin
            res[n] = '{word_cnt, hit_cnt, 1'b0, 1'b1};
            n++;
         end
      end else begin
         plen = (int'(cfg_len) > PAT_MAX) ? PAT_MAX : int'(cfg_len);
         if (!in_word) begin
            in_word = 1'b1;
            word_chars = 0;
            word_hit = (plen == 0);
            if (word_cnt != '1) begin
               word_cnt = word_cnt + 1'b1;
            end
         end
         // The newest character enters slot zero.
         for (int i = PAT_MAX - 1; i > 0; i--) begin
            win[i] = win[i - 1];
         end
         win[0] = to_lower(c);
         if (word_chars < PAT_MAX) begin
            word_chars++;
         end
         if (plen > 0 && word_chars >= plen) begin
            eq = 1'b1;
            for (int i = 0; i < plen; i++) begin
               if (win[i] != to_lower(pat_byte(plen - 1 - i))) begin
                  eq = 1'b0;
               end
            end
            if (eq) begin
               word_hit = 1'b1;
            end
         end
      end
   endtask

   // Offers one request after a random gap and waits for its handshake.
   task automatic send_req(input kind_type k, input logic [7:0] c);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= k;
      req_tdata <= c;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   task automatic push_text(input kind_type k, input logic [7:0] c);
      int           n;
      rsp_item_type res [2];
      send_req(k, c);
      scan_text(k, c, n, res);
      for (int i = 0; i < n; i++) begin
         pending_matches.push_back(res[i]);
      end
      sent_items++;
   endtask

   // One word built around the pattern, or a long random word, then a separator.
   task automatic send_word();
      int pre;
      int suf;
      int total;
      logic [7:0] c;
      total = 0;
      if ($urandom_range(9) == 0) begin
         pre = $urandom_range(33, 40);
         for (int i = 0; i < pre; i++) begin
            push_text(KIND_CHAR, pick_letter());
         end
      end else begin
         pre = $urandom_range(4);
         for (int i = 0; i < pre; i++) begin
            push_text(KIND_CHAR, pick_letter());
         end
         total = pre;
         if (cur_eff > 0 && $urandom_range(1) == 1) begin
            for (int i = 0; i < cur_eff; i++) begin
               c = cur_pat[i];
               if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) &&
                   $urandom_range(1) == 1) begin
                  c = c ^ 8'h20;
               end
               push_text(KIND_CHAR, c);
            end
            total += cur_eff;
         end
         suf = $urandom_range(4);
         if (total + suf == 0) begin
            suf = 1;
         end
         for (int i = 0; i < suf; i++) begin
            push_text(KIND_CHAR, pick_letter());
         end
      end
      push_text(KIND_CHAR, pick_separator());
   endtask

   // Holds the sender until every expected result has arrived.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_matches.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Writes all five registers back to back; the block must be idle.
   task automatic program_pattern(input logic [LEN_REG_BITS-1:0] len,
                                  input logic [PAT_WORD_BITS-1:0] w [NUM_PAT_WORDS]);
      csr_wr_en <= 1'b1;
      csr_index <= REG_PATTERN_LENGTH;
      csr_data <= PAT_WORD_BITS'(len);
      @(posedge clock);
      for (int i = 0; i < NUM_PAT_WORDS; i++) begin
         csr_index <= csr_index_type'(REG_PATTERN_WORD_0 + i);
         csr_data <= w[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      cfg_len = len;
      for (int i = 0; i < NUM_PAT_WORDS; i++) begin
         cfg_words[i] = w[i];
      end
   endtask

   task automatic set_idle(input int mode);
      case (mode)
         1: begin
            req_idle_pct = 74;
            rsp_stall_pct = 0;
         end
         2: begin
            req_idle_pct = 0;
            rsp_stall_pct = 74;
         end
         3: begin
            req_idle_pct = 25;
            rsp_stall_pct = 25;
         end
         default: begin
            req_idle_pct = 0;
            rsp_stall_pct = 0;
         end
      endcase
   endtask

   // Compare every accepted result with the oldest expectation.
   always @(posedge clock) begin : check_rsp
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[15:0], rsp_tdata[31:16], rsp_tuser, rsp_tlast};
         if (pending_matches.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result: index %0d count %0d summary %0b last %0b",
                        got.word_index, got.match_count, got.is_summary, got.last);
            end
         end else begin
            want = pending_matches.pop_front();
            if (got != want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected index %0d count %0d summary %0b last %0b",
                           want.word_index, want.match_count, want.is_summary,
                           want.last);
                  $display("          got index %0d count %0d summary %0b last %0b",
                           got.word_index, got.match_count, got.is_summary, got.last);
               end
            end
         end
      end
   end

   initial begin
      int               n;
      int               r;
      int               plen;
      rsp_item_type     res [2];
      logic [PAT_WORD_BITS-1:0] wv [NUM_PAT_WORDS];
      dir_row_type      row;

      for (int i = 0; i < NUM_PAT_WORDS; i++) begin
         cfg_words[i] = '0;
      end
      for (int i = 0; i < PAT_MAX; i++) begin
         win[i] = 8'h00;
         cur_pat[i] = 8'h00;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; typed rows carry their own expectation.
      for (int i = 0; i < DIR_ROWS; i++) begin
         row = DIR_TABLE[i];
         if (row.op == ROW_PATTERN) begin
            wait_drained();
            repeat (SLACK_CYCLES) @(posedge clock);
            wv[0] = row.w0;
            for (int j = 1; j < NUM_PAT_WORDS; j++) begin
               wv[j] = {$urandom, $urandom};
            end
            program_pattern(row.ch[LEN_REG_BITS-1:0], wv);
         end else begin
            send_req(row.kind, row.ch);
            scan_text(row.kind, row.ch, n, res);
            if (row.typed) begin
               if (row.n >= 1) begin
                  pending_matches.push_back(row.e0);
               end
               if (row.n == 2) begin
                  pending_matches.push_back(row.e1);
               end
            end else begin
               for (int j = 0; j < n; j++) begin
                  pending_matches.push_back(res[j]);
               end
            end
         end
      end

      // Random text under a new pattern and idle mode per phase.
      for (int p = 0; p < PHASES; p++) begin
         plen = PHASE_LEN[p];
         cur_eff = (plen > PAT_MAX) ? PAT_MAX : plen;
         for (int k = 0; k < PAT_MAX; k++) begin
            cur_pat[k] = (k < cur_eff) ? pick_letter() : 8'($urandom_range(255));
         end
         if (p == 6) begin
            cur_pat[$urandom_range(cur_eff - 1)] = pick_separator();
         end
         for (int k = 0; k < PAT_MAX; k++) begin
            wv[k / 8][8 * (k % 8) +: 8] = cur_pat[k];
         end
         wait_drained();
         repeat (SLACK_CYCLES) @(posedge clock);
         program_pattern(LEN_REG_BITS'(plen), wv);
         set_idle(p % 4);
         sent_items = 0;
         while (sent_items < PHASE_ITEMS) begin
            r = $urandom_range(99);
            if (r == 0) begin
               wait_drained();
            end else if (r < 4) begin
               push_text(KIND_END, 8'($urandom_range(255)));
            end else if (r < 10) begin
               push_text(KIND_CHAR, 8'($urandom_range(255)));
            end else begin
               send_word();
            end
         end
         push_text(KIND_END, 8'($urandom_range(255)));
      end

      // A burst of one-letter words under an empty pattern.
      wait_drained();
      repeat (SLACK_CYCLES) @(posedge clock);
      for (int i = 0; i < NUM_PAT_WORDS; i++) begin
         wv[i] = {$urandom, $urandom};
      end
      program_pattern('0, wv);
      set_idle(0);
      for (int i = 0; i < SHORT_WORDS; i++) begin
         push_text(KIND_CHAR, pick_letter());
         push_text(KIND_CHAR, 8'h20);
      end
      push_text(KIND_END, 8'h00);

      wait_drained();
      repeat (SLACK_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_matches.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
